@@ hdl/brc_pkg.sv @@
// ============================================================================
// brc_pkg
// Shared types and constants for the reference-count block allocator.
// ============================================================================
package brc_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed port widths
    localparam int CFG_W       = 13;
    localparam int BN_W        = 12;
    localparam int COUNT_OUT_W = 32;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_INC   = 2'd1,
        OP_DEC   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_MAXED   = 3'd2,
        ST_ZERO    = 3'd3,
        ST_NOSPACE = 3'd4
    } status_t;

    // Flags from the shared count unit
    typedef struct packed {
        logic zero;
        logic full;
    } cnt_flags_t;

    // One result transaction
    typedef struct packed {
        status_t                status;
        logic [BN_W-1:0]        block;
        logic [COUNT_OUT_W-1:0] count;
    } result_t;

endpackage

@@ hdl/block_refcount_allocator_core.sv @@
// ============================================================================
// block_refcount_allocator_core
// Next-fit block allocator with a per-block reference count table.
// ============================================================================
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  -----------------------------------
//  in       in   in_valid / in_stall  opcode, block_number
//  out      out  out_valid/out_stall  status, allocated_block, ref_count
//  cfg      in   cfg_wr_en            cfg_wr_data (block_count)
//
//  Increment, decrement and read issue the RAM read on acceptance, then test and
//  write back through the shared count unit; out of range, they finish on acceptance.
//  Allocate inspects 1..n blocks, n = block_count clamped to MAX_BLOCKS (none
//  with no blocks); the scan issues one RAM read per cycle and tests the previous one.
//  After reset a clearing pass writes zero to all MAX_BLOCKS entries, one
//  per cycle; in_stall stays high throughout the pass.
//  A finished result waits in a pending register while out_stall is high;
//  in_stall is high while an item is in progress or pending.
//
module block_refcount_allocator_core
    import brc_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,

    // request transaction
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [BN_W-1:0]        block_number,

    // result transaction
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             status,
    output logic [BN_W-1:0]        allocated_block,
    output logic [COUNT_OUT_W-1:0] ref_count
);

    // Index width, count-of-blocks width, common compare width
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int NW   = IW + 1;
    localparam int CMPW = (NW > CFG_W) ? NW : CFG_W;

    localparam logic [IW-1:0]   LAST_IDX = IW'(MAX_BLOCKS - 1);
    localparam logic [CMPW-1:0] MAX_CMP  = CMPW'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESP
    } state_t;

    state_t                 state_reg,       state_next;
    logic [IW-1:0]          clr_idx_reg,     clr_idx_next;
    logic [CFG_W-1:0]       block_count_reg;
    op_t                    op_reg,          op_next;
    logic [IW-1:0]          addr_reg,        addr_next;   // block under test
    logic [NW-1:0]          n_reg,           n_next;      // effective block count
    logic [NW-1:0]          left_reg,        left_next;   // scan entries remaining
    logic [IW-1:0]          ptr_reg,         ptr_next;    // next-fit pointer
    result_t                pend_reg,        pend_next;
    result_t                out_reg,         out_next;
    logic                   out_valid_reg,   out_valid_next;

    // RAM and count unit hookup
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;
    logic [IW-1:0]          mem_raddr;
    logic [COUNT_BITS-1:0]  rd_data;
    cnt_flags_t             alu_flags;
    logic [COUNT_BITS-1:0]  alu_sum;

    // Finish path
    logic                   fin;
    result_t                fin_res;
    logic                   out_free;

    // Helpers
    logic [CMPW-1:0]        bc_cmp;
    logic [NW-1:0]          n_eff;
    logic [IW-1:0]          head;
    logic [NW-1:0]          scan_inc;
    logic [IW-1:0]          scan_nxt;
    logic                   bn_bad;

    brc_count_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (COUNT_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    brc_count_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .op    (op_reg),
        .count (rd_data),
        .flags (alu_flags),
        .sum   (alu_sum)
    );

    // block_count above the table size is clamped to MAX_BLOCKS
    assign bc_cmp = CMPW'(block_count_reg);
    assign n_eff  = (bc_cmp > MAX_CMP) ? NW'(MAX_CMP) : NW'(bc_cmp);

    // Pointer left beyond a lowered block count restarts at zero
    assign head   = (NW'(ptr_reg) < n_eff) ? ptr_reg : '0;

    // Circular successor of the block under test
    assign scan_inc = NW'(addr_reg) + NW'(1);
    assign scan_nxt = (scan_inc < n_reg) ? IW'(scan_inc) : '0;

    assign bn_bad   = (CMPW'(block_number) >= CMPW'(n_eff));

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        n_next         = n_reg;
        left_next      = left_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_raddr = addr_reg;

        fin     = 1'b0;
        fin_res = '{status: ST_OK, block: '0, count: '0};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
            end

            S_IDLE:
            begin
                // Speculative read for index ops
                mem_raddr = IW'(block_number);
                if (in_valid)
                begin
                    op_next = op_t'(opcode);
                    n_next  = n_eff;
                    if (opcode == OP_ALLOC)
                    begin
                        if (n_eff == '0)
                        begin
                            fin            = 1'b1;
                            fin_res.status = ST_NOSPACE;
                        end
                        else
                        begin
                            mem_raddr  = head;
                            addr_next  = head;
                            left_next  = n_eff;
                            state_next = S_SCAN;
                        end
                    end
                    else if (bn_bad)
                    begin
                        fin            = 1'b1;
                        fin_res.status = ST_RANGE;
                    end
                    else
                    begin
                        addr_next  = IW'(block_number);
                        state_next = S_EXEC;
                    end
                end
            end

            S_SCAN:
            begin
                // rd_data holds addr_reg; issue its successor meanwhile
                mem_raddr = scan_nxt;
                if (alu_flags.zero)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = COUNT_BITS'(1);
                    ptr_next      = scan_nxt;
                    fin           = 1'b1;
                    fin_res.block = BN_W'(addr_reg);
                end
                else if (left_reg == NW'(1))
                begin
                    fin            = 1'b1;
                    fin_res.status = ST_NOSPACE;
                end
                else
                begin
                    addr_next = scan_nxt;
                    left_next = left_reg - NW'(1);
                end
            end

            S_EXEC:
            begin
                fin       = 1'b1;
                mem_wdata = alu_sum;
                case (op_reg)
                    OP_INC:
                    begin
                        if (alu_flags.full)
                        begin
                            fin_res.status = ST_MAXED;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                    OP_DEC:
                    begin
                        if (alu_flags.zero)
                        begin
                            fin_res.status = ST_ZERO;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        fin_res.count = COUNT_OUT_W'(rd_data);
                    end
                    default:
                    begin
                        fin_res.status = ST_OK;
                    end
                endcase
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Finished item goes straight out if the output slot frees up
        if (fin)
        begin
            if (out_free)
            begin
                out_next       = fin_res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = fin_res;
                state_next = S_RESP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            block_count_reg <= BLOCK_COUNT_RST;
            op_reg          <= OP_ALLOC;
            addr_reg        <= '0;
            n_reg           <= '0;
            left_reg        <= '0;
            ptr_reg         <= '0;
            pend_reg        <= '0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            n_reg         <= n_next;
            left_reg      <= left_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                block_count_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign allocated_block = out_reg.block;
    assign ref_count       = out_reg.count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Nothing is produced or accepted during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg && in_stall)
        else $error("activity during clearing pass");

    // A blocked result is parked and the output slot stays full
    a_park: assert property (@(posedge clk) disable iff (!rst_n)
        fin && !out_free |=> state_reg == S_RESP && out_valid_reg)
        else $error("finished result not parked");

    // The scan never runs with an exhausted budget
    a_scan_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> left_reg != '0 && left_reg <= n_reg)
        else $error("scan budget out of bounds");

    // A found free block moves the pointer past it
    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && alu_flags.zero |=> ptr_reg == $past(scan_nxt))
        else $error("pointer not advanced past granted block");

endmodule

@@ hdl/brc_count_ram.sv @@
// ============================================================================
// brc_count_ram
// Reference-count storage: one write port, one read port, registered read.
// ============================================================================
module brc_count_ram
    import brc_pkg::*;
#(
    parameter int DEPTH = MAX_BLOCKS_DEF,
    parameter int AW    = $clog2(MAX_BLOCKS_DEF),
    parameter int DW    = COUNT_BITS_DEF
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/brc_count_alu.sv @@
// ============================================================================
// brc_count_alu
// Shared count unit: zero and saturation tests plus a single +1/-1 adder.
// ============================================================================
module brc_count_alu
    import brc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  op_t                   op,
    input  logic [COUNT_BITS-1:0] count,
    output cnt_flags_t            flags,
    output logic [COUNT_BITS-1:0] sum
);

    logic [COUNT_BITS-1:0] step;

    // -1 is all ones in two's complement
    assign step       = (op == OP_DEC) ? '1 : COUNT_BITS'(1);
    assign sum        = count + step;
    assign flags.zero = (count == '0);
    assign flags.full = &count;

endmodule
